### sv/dfx_pkg.sv
// Package for the delimited frame extractor: widths, reset values,
// register indexes, phase codes and the result struct shared by all modules.
// No dependencies.
package dfx_pkg;

   localparam int DATA_WIDTH          = 8;
   localparam int WIDE_WIDTH          = 16;
   localparam int FRAME_LEN_WIDTH     = 24;
   localparam int PATTERN_WIDTH       = 32;
   localparam int DEFAULT_COUNT_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int PHASE_COUNT_WIDTH   = 3;

   // delimiter length in bytes
   localparam logic [PHASE_COUNT_WIDTH-1:0] DELIM_BYTES = 3'd4;

   localparam logic [FRAME_LEN_WIDTH-1:0] FRAME_LEN_RESET     = 24'd4096;
   localparam logic [PATTERN_WIDTH-1:0]   START_PATTERN_RESET = '0;
   localparam logic [PATTERN_WIDTH-1:0]   END_PATTERN_RESET   = '0;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_PATTERN = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_PATTERN   = 2'd2;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TAIL    = 2'd2
   } phase_type;

   // one result beat handed from the core to the output stage
   typedef struct packed {
      logic                  valid;
      logic                  is_end;
      logic [DATA_WIDTH-1:0] data;
   } step_result_type;

endpackage

### sv/dfx_core.sv
// Deframer core: phase state machine, delimiter window and payload counter.
// Depends on dfx_pkg.
module dfx_core #(
   parameter int COUNT_WIDTH = dfx_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic [dfx_pkg::DATA_WIDTH-1:0]       data_byte,
   input  logic [dfx_pkg::FRAME_LEN_WIDTH-1:0]  frame_length,
   input  logic [dfx_pkg::PATTERN_WIDTH-1:0]    start_pattern,
   input  logic [dfx_pkg::PATTERN_WIDTH-1:0]    end_pattern,
   output dfx_pkg::step_result_type             result
);
   import dfx_pkg::*;

   localparam int WIN_WIDTH = PATTERN_WIDTH - DATA_WIDTH;
   localparam int CMP_WIDTH =
      (COUNT_WIDTH > FRAME_LEN_WIDTH) ? COUNT_WIDTH : FRAME_LEN_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type                    phase_ff, phase_in;
   logic [WIN_WIDTH-1:0]         recent_ff, recent_in;
   logic [PHASE_COUNT_WIDTH-1:0] bip_ff, bip_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;

   logic [PATTERN_WIDTH-1:0]     window;
   logic [PHASE_COUNT_WIDTH-1:0] bip_inc;
   logic                         window_full;
   logic                         start_hit;
   logic                         end_hit;
   logic [COUNT_WIDTH-1:0]       count_inc;
   logic                         payload_done;

   // window and counter arithmetic
   always_comb begin
      window      = {recent_ff, data_byte};
      bip_inc     = (bip_ff >= DELIM_BYTES) ? bip_ff : bip_ff + 1'b1;
      window_full = (bip_inc >= DELIM_BYTES);
      start_hit   = window_full && (window == start_pattern);
      end_hit     = window_full && (window == end_pattern);
      count_inc   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      payload_done = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(frame_length)) ||
                     (count_inc == COUNT_MAX);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               if (payload_done) phase_in = PH_TAIL;
            end
            PH_TAIL: begin
               if (end_hit) phase_in = PH_HUNT;
            end
            default: begin
               if (start_hit) phase_in = PH_PAYLOAD;
            end
         endcase
      end
   end

   // datapath updates and result beat
   always_comb begin
      recent_in     = recent_ff;
      bip_in        = bip_ff;
      count_in      = count_ff;
      result.valid  = 1'b0;
      result.is_end = 1'b0;
      result.data   = '0;
      if (fire) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               result.valid = 1'b1;
               result.data  = data_byte;
               count_in     = count_inc;
               if (payload_done) begin
                  recent_in = '0;
                  bip_in    = '0;
               end
            end
            PH_TAIL: begin
               if (end_hit) begin
                  result.valid  = 1'b1;
                  result.is_end = 1'b1;
                  count_in      = '0;
                  recent_in     = '0;
                  bip_in        = '0;
               end else begin
                  recent_in = window[WIN_WIDTH-1:0];
                  bip_in    = bip_inc;
               end
            end
            default: begin
               if (start_hit) begin
                  count_in  = '0;
                  recent_in = '0;
                  bip_in    = '0;
               end else begin
                  recent_in = window[WIN_WIDTH-1:0];
                  bip_in    = bip_inc;
               end
            end
         endcase
      end
   end

   // hold state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         recent_ff <= '0;
         bip_ff    <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         recent_ff <= recent_in;
         bip_ff    <= bip_in;
         count_ff  <= count_in;
      end
   end

   a_end_from_tail: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.is_end) |-> (phase_ff == PH_TAIL))
      else $error("frame end raised outside tail phase");

   a_quiet_outside_payload: assert property (@(posedge clock) disable iff (reset)
      (result.valid && (phase_ff != PH_PAYLOAD)) |-> result.is_end)
      else $error("payload beat outside payload phase");

   a_payload_starts_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && (phase_ff == PH_HUNT) && (phase_in == PH_PAYLOAD)) |=>
      ((count_ff == '0) && (bip_ff == '0)))
      else $error("payload phase entered with stale count");

   a_bip_saturates: assert property (@(posedge clock) disable iff (reset)
      bip_ff <= DELIM_BYTES)
      else $error("phase byte count beyond delimiter length");

endmodule

### sv/dfx_out.sv
// Result register stage: holds one result beat until the sink takes it.
// Depends on dfx_pkg.
module dfx_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dfx_pkg::step_result_type             result,
   output logic                                 can_load,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_frame_end,
   output logic [dfx_pkg::DATA_WIDTH-1:0]       rsp_payload_byte,
   output logic [dfx_pkg::WIDE_WIDTH-1:0]       rsp_wide_pixel
);
   import dfx_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  is_end_ff;
   logic [DATA_WIDTH-1:0] data_ff;

   // free when empty or draining this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) valid_in = result.valid;
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register: load only a new beat
   always_ff @(posedge clock) begin
      if (can_load && result.valid) begin
         is_end_ff <= result.is_end;
         data_ff   <= result.data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_is_frame_end = is_end_ff;
   assign rsp_payload_byte = data_ff;
   assign rsp_wide_pixel   = {data_ff, {(WIDE_WIDTH-DATA_WIDTH){1'b0}}};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !can_load)
      else $error("held result beat could be overwritten");

   a_end_carries_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && is_end_ff) |-> (data_ff == '0))
      else $error("frame end beat carries payload data");

endmodule

### sv/delimited_frame_extractor.sv
// Top level of the delimited frame extractor: configuration registers,
// deframer core and result register. Depends on dfx_pkg, dfx_core, dfx_out.
//
//   channel | direction | ports                          | moves
//   req     | in        | req_valid/ready, req_data_byte | one received byte per beat
//   rsp     | out       | rsp_valid/ready, rsp_*         | payload byte or frame end
//   csr     | in        | csr_valid/ready, index, data   | one register write per beat
//
// One byte is taken per cycle while req_ready is high; any result it yields lands in
// the result register on the same edge and appears in the cycle after the byte is accepted.
// The single result register sets the rate: req_ready drops only while a
// result is held and rsp_ready is low. csr_ready is always high.
// Reset (synchronous) returns to start hunting with frame_length 4096 and
// both patterns zero.
module delimited_frame_extractor #(
   parameter int COUNT_WIDTH = dfx_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dfx_pkg::DATA_WIDTH-1:0]       req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_is_frame_end,
   output logic [dfx_pkg::DATA_WIDTH-1:0]       rsp_payload_byte,
   output logic [dfx_pkg::WIDE_WIDTH-1:0]       rsp_wide_pixel,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dfx_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dfx_pkg::PATTERN_WIDTH-1:0]    csr_data
);
   import dfx_pkg::*;

   logic [FRAME_LEN_WIDTH-1:0] frame_len_ff;
   logic [PATTERN_WIDTH-1:0]   start_pat_ff;
   logic [PATTERN_WIDTH-1:0]   end_pat_ff;
   logic                       can_load;
   logic                       req_fire;
   step_result_type            result;

   assign csr_ready = 1'b1;
   assign req_ready = can_load;
   assign req_fire  = req_valid && req_ready;

   // write configuration registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= FRAME_LEN_RESET;
         start_pat_ff <= START_PATTERN_RESET;
         end_pat_ff   <= END_PATTERN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_LENGTH:  frame_len_ff <= csr_data[FRAME_LEN_WIDTH-1:0];
            CSR_START_PATTERN: start_pat_ff <= csr_data;
            CSR_END_PATTERN:   end_pat_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   dfx_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (req_fire),
      .data_byte     (req_data_byte),
      .frame_length  (frame_len_ff),
      .start_pattern (start_pat_ff),
      .end_pattern   (end_pat_ff),
      .result        (result)
   );

   dfx_out u_out (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_frame_end (rsp_is_frame_end),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_wide_pixel   (rsp_wide_pixel)
   );

   a_result_from_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_fire))
      else $error("result appeared without an accepted byte");

endmodule
